// ===== hw/rtl/sweg_pkg.sv =====
// Package for the sliding-window event guard: sizes, command codes,
// controller states, and the structs passed between the controller and the store.
// Depends on nothing; every other RTL file refers to it by scoped names.
package sweg_pkg;

  localparam int LOG_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int STAMP_W   = 32;
  localparam int WIN_W     = 16;
  localparam int OUT_CNT_W = 11;
  localparam int COUNT_MAX = 2047;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_CHECK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [STAMP_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                 valid;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

  // Clamps an internal count to the width of the reported field.
  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    if (CNT_W > OUT_CNT_W && c > CNT_W'(COUNT_MAX)) begin
      return '1;
    end
    return OUT_CNT_W'(c);
  endfunction

endpackage

// ===== hw/rtl/sweg_store.sv =====
// Timestamp log memory: one write port and one read port, registered read data.
// Depends on sweg_pkg for depth, widths and the request struct.
module sweg_store (
  input  logic                                clk,
  input  sweg_pkg::mem_req_t                  req,
  output logic [sweg_pkg::STAMP_W-1:0]        rd_data
);

  logic [sweg_pkg::STAMP_W-1:0] mem [sweg_pkg::LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sweg_ctrl.sv =====
// Sequencer that walks the log: reads each stamp, compacts in place on a record,
// appends the new stamp and produces the count. Depends on sweg_pkg.
module sweg_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         command,
  input  logic [sweg_pkg::STAMP_W-1:0]       now_time,
  input  logic [sweg_pkg::WIN_W-1:0]         window_length,
  input  logic                               res_take,
  input  logic [sweg_pkg::STAMP_W-1:0]       rd_data,
  output logic                               in_ready,
  output sweg_pkg::mem_req_t                 mem_req,
  output sweg_pkg::result_t                  result
);

  sweg_pkg::state_t state, state_next;

  logic [1:0]                     cmd;
  logic [sweg_pkg::STAMP_W-1:0]   now_stamp;
  logic [sweg_pkg::STAMP_W-1:0]   cutoff;
  logic [sweg_pkg::STAMP_W-1:0]   cutoff_next;
  logic [sweg_pkg::WIN_W-1:0]     win_eff;
  logic [sweg_pkg::CNT_W-1:0]     stored_count;
  logic [sweg_pkg::CNT_W-1:0]     rd_idx;
  logic [sweg_pkg::CNT_W-1:0]     k;
  logic [sweg_pkg::CNT_W-1:0]     res_count;
  logic                           rd_pend;
  logic                           is_record;
  logic                           keep;
  logic                           more;
  logic                           room;

  // A zero window behaves as one second; the cutoff saturates at zero.
  always_comb begin
    win_eff = (window_length == '0) ? sweg_pkg::WIN_W'(1) : window_length;
    if (now_time >= sweg_pkg::STAMP_W'(win_eff)) begin
      cutoff_next = now_time - sweg_pkg::STAMP_W'(win_eff);
    end else begin
      cutoff_next = '0;
    end
  end

  assign is_record = (cmd == sweg_pkg::CMD_RECORD);
  assign keep      = (rd_data >= cutoff);
  assign more      = (rd_idx < stored_count);
  assign room      = (k < sweg_pkg::CNT_W'(sweg_pkg::LOG_DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      sweg_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (command == sweg_pkg::CMD_CLEAR) ? sweg_pkg::ST_DONE
                                                        : sweg_pkg::ST_SCAN;
        end
      end
      sweg_pkg::ST_SCAN: begin
        if (!more && !rd_pend) begin
          state_next = sweg_pkg::ST_FINISH;
        end
      end
      sweg_pkg::ST_FINISH: begin
        state_next = sweg_pkg::ST_DONE;
      end
      sweg_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = sweg_pkg::ST_IDLE;
        end
      end
      default: state_next = sweg_pkg::ST_IDLE;
    endcase
  end

  // The read runs one entry ahead of the write-back, and the write index never
  // passes the read index, so a write never lands on an entry still to be read.
  always_comb begin
    in_ready        = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = rd_idx[sweg_pkg::ADDR_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = k[sweg_pkg::ADDR_W-1:0];
    mem_req.wr_data = rd_data;
    result.valid    = 1'b0;
    result.count    = sweg_pkg::sat_count(res_count);
    unique case (state)
      sweg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sweg_pkg::ST_SCAN: begin
        mem_req.rd_en = more;
        mem_req.wr_en = rd_pend && keep && is_record;
      end
      sweg_pkg::ST_FINISH: begin
        mem_req.wr_en   = is_record && room;
        mem_req.wr_data = now_stamp;
      end
      sweg_pkg::ST_DONE: begin
        result.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sweg_pkg::ST_IDLE;
      stored_count <= '0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
      k            <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        sweg_pkg::ST_IDLE: begin
          if (start) begin
            rd_idx  <= '0;
            k       <= '0;
            rd_pend <= 1'b0;
            if (command == sweg_pkg::CMD_CLEAR) begin
              stored_count <= '0;
            end
          end
        end
        sweg_pkg::ST_SCAN: begin
          rd_pend <= more;
          if (more) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (rd_pend && keep) begin
            k <= k + 1'b1;
          end
        end
        sweg_pkg::ST_FINISH: begin
          if (is_record) begin
            stored_count <= room ? k + 1'b1 : k;
          end
        end
        sweg_pkg::ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == sweg_pkg::ST_IDLE && start) begin
      cmd       <= command;
      now_stamp <= now_time;
      cutoff    <= cutoff_next;
      res_count <= '0;
    end else if (state == sweg_pkg::ST_FINISH) begin
      res_count <= (is_record && room) ? k + 1'b1 : k;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_event_guard.sv =====
// Top level of the sliding-window event guard: stream ports, configuration
// registers, output register. Depends on sweg_pkg, sweg_ctrl and sweg_store.
//
//   Channel | Direction | Handshake         | Contents
//   s_*     | in        | s_tvalid/s_tready | tdata now_time, tuser command
//   m_*     | out       | m_tvalid/m_tready | tdata event_count, tripped
//   cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// For a record or check the sequencer reads one log entry per cycle through the single
// read port, then finishes and presents the result.
// A clear goes from idle straight to the done state with no scan. Reset empties the log at
// once; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// the sequencer holds its result if that register is still occupied.
module sliding_window_event_guard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] now_time
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] event_count, [11] tripped, [15:12] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [sweg_pkg::WIN_W-1:0]     window_length;
  logic [sweg_pkg::OUT_CNT_W-1:0] event_limit;
  logic [sweg_pkg::STAMP_W-1:0]   rd_data;
  logic                           res_take;
  logic                           tripped_next;
  sweg_pkg::mem_req_t             mem_req;
  sweg_pkg::result_t              result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= sweg_pkg::WIN_W'(60);
      event_limit   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sweg_pkg::REG_WINDOW: window_length <= cfg_data[sweg_pkg::WIN_W-1:0];
        sweg_pkg::REG_LIMIT:  event_limit   <= cfg_data[sweg_pkg::OUT_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign res_take     = !m_tvalid || m_tready;
  assign tripped_next = (event_limit != '0) && (result.count >= event_limit);

  sweg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (s_tvalid && s_tready),
    .command       (s_tuser),
    .now_time      (s_tdata),
    .window_length (window_length),
    .res_take      (res_take),
    .rd_data       (rd_data),
    .in_ready      (s_tready),
    .mem_req       (mem_req),
    .result        (result)
  );

  sweg_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && result.valid) begin
      m_tdata <= {4'b0000, tripped_next, result.count};
    end
  end

endmodule

// ===== dv/tb_sliding_window_event_guard.sv =====
// Self-checking testbench for sliding_window_event_guard: directed and random command streams
// with a built-in predictor of the timestamp log, under several handshake pressure settings.
// Depends on sweg_pkg and the RTL of sliding_window_event_guard.
module tb_sliding_window_event_guard;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         PHASE_ITEMS    = 128;

  typedef struct {
    logic [sweg_pkg::OUT_CNT_W-1:0] count;
    logic                           tripped;
  } guard_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         cfg_ready;

  // Predictor state: a copy of the registers and of the stamp log.
  logic [15:0]                  win_len   = 16'd60;
  logic [10:0]                  evt_limit = 11'd0;
  logic [sweg_pkg::STAMP_W-1:0] stamp_log [sweg_pkg::LOG_DEPTH];
  int                           logged_stamps = 0;

  guard_result_t expected_results[$];
  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int failures        = 0;
  int items_accepted  = 0;
  int cfg_writes      = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;

  sliding_window_event_guard DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one command to the predicted log and returns the result it should give.
  function automatic guard_result_t predict_guard(input logic [1:0] cmd, input logic [31:0] now);
    guard_result_t res;
    logic [31:0]   span;
    logic [31:0]   cutoff;
    int            kept;
    int            i;
    span        = (win_len == 16'd0) ? 32'd1 : {16'd0, win_len};
    cutoff      = (now >= span) ? now - span : 32'd0;
    kept        = 0;
    res.count   = '0;
    res.tripped = 1'b0;
    if (cmd == sweg_pkg::CMD_CLEAR) begin
      logged_stamps = 0;
      return res;
    end
    if (cmd == sweg_pkg::CMD_RECORD) begin
      for (i = 0; i < logged_stamps; i++) begin
        if (stamp_log[i] >= cutoff) begin
          stamp_log[kept] = stamp_log[i];
          kept++;
        end
      end
      if (kept < sweg_pkg::LOG_DEPTH) begin
        stamp_log[kept] = now;
        kept++;
      end
      logged_stamps = kept;
    end else begin
      for (i = 0; i < logged_stamps; i++) begin
        if (stamp_log[i] >= cutoff) kept++;
      end
    end
    res.count   = (kept > sweg_pkg::COUNT_MAX) ? sweg_pkg::OUT_CNT_W'(sweg_pkg::COUNT_MAX)
                                               : sweg_pkg::OUT_CNT_W'(kept);
    res.tripped = (evt_limit != 11'd0) && (res.count >= evt_limit);
    return res;
  endfunction

  // Input side: predict on every accepted command and track register writes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(predict_guard(s_tuser, s_tdata));
      items_accepted++;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == sweg_pkg::REG_WINDOW) win_len = cfg_data;
      else evt_limit = cfg_data[10:0];
      cfg_writes++;
    end
  end

  always @(posedge clk) begin : check_results
    guard_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting: tdata %h", m_tdata);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (m_tdata[10:0] !== exp_res.count) begin
          $error("event_count mismatch: expected %0d, actual %0d", exp_res.count, m_tdata[10:0]);
          failures++;
        end
        if (m_tdata[11] !== exp_res.tripped) begin
          $error("tripped mismatch: expected %0d, actual %0d", exp_res.tripped, m_tdata[11]);
          failures++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int sender_gap();
    int g = 0;
    while (g < 40 && $urandom_range(99) < tx_idle_pct) g++;
    return g;
  endfunction

  // Holds a command on the input channel until it is transferred.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] now);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= now;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it.
  task automatic cfg_write(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] window, input logic [10:0] limit);
    wait_drained();
    cfg_write(sweg_pkg::REG_WINDOW, window);
    cfg_write(sweg_pkg::REG_LIMIT, {5'd0, limit});
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pressure(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Reset values: window of 60 seconds and tripping disabled.
  task automatic test_reset_defaults();
    set_pressure(0, 0);
    send_item(sweg_pkg::CMD_CHECK, 32'd0);
    send_item(sweg_pkg::CMD_RECORD, 32'd100);
    send_item(sweg_pkg::CMD_RECORD, 32'd130);
    send_item(sweg_pkg::CMD_RECORD, 32'd170);
    send_item(CMD_UNUSED, 32'd200);
  endtask

  task automatic test_window_edges();
    set_pressure(17, 17);
    // A zero window behaves as one second.
    configure(16'd0, 11'd0);
    send_item(sweg_pkg::CMD_RECORD, 32'd1000);
    send_item(sweg_pkg::CMD_RECORD, 32'd1001);
    send_item(sweg_pkg::CMD_CHECK, 32'd1002);
    configure(16'hFFFF, 11'd0);
    send_item(sweg_pkg::CMD_RECORD, 32'hFFFF_FFFF);
    // Cutoff saturates at zero, and a stamp ahead of now still counts.
    send_item(sweg_pkg::CMD_CHECK, 32'd0);
    send_item(sweg_pkg::CMD_RECORD, 32'd5);
    send_item(sweg_pkg::CMD_CLEAR, 32'd5);
  endtask

  task automatic test_limit_and_clear();
    set_pressure(17, 17);
    configure(16'd10, 11'd1);
    send_item(sweg_pkg::CMD_RECORD, 32'h7FFF_FFFF);
    configure(16'd10, 11'd2);
    send_item(sweg_pkg::CMD_RECORD, 32'h8000_0000);
    configure(16'd10, 11'd1024);
    send_item(sweg_pkg::CMD_CHECK, 32'h8000_0000);
    // A clear never reports a trip, even with a limit of one.
    configure(16'd10, 11'd1);
    send_item(sweg_pkg::CMD_CLEAR, 32'h8000_0001);
    send_item(sweg_pkg::CMD_CHECK, 32'h8000_0001);
  endtask

  // Mostly bursts of nearby timestamps from a random base, with some noise.
  task automatic run_random_phase(input int n_items);
    int          sent;
    int          burst;
    int          roll;
    logic [31:0] t;
    logic [1:0]  cmd;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        t     = $urandom;
        burst = $urandom_range(3, 12);
        repeat (burst) begin
          roll = $urandom_range(99);
          if (roll < 72) cmd = sweg_pkg::CMD_RECORD;
          else if (roll < 92) cmd = sweg_pkg::CMD_CHECK;
          else cmd = CMD_UNUSED;
          roll = $urandom_range(99);
          if (roll < 60) t = t + $urandom_range(0, 3);
          else if (roll < 85) t = t + $urandom_range(0, win_len + 2);
          else t = t - $urandom_range(0, 5);
          send_item(cmd, t);
          sent++;
        end
        if ($urandom_range(99) < 30 || logged_stamps > 200) begin
          send_item(sweg_pkg::CMD_CLEAR, t);
          sent++;
        end
      end else begin
        cmd = 2'($urandom_range(0, 3));
        send_item(cmd, $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    configure(16'd4, 11'd3);
    set_pressure(0, 0);
    run_random_phase(PHASE_ITEMS);
    configure(16'($urandom_range(1, 20)), 11'($urandom_range(1, 10)));
    set_pressure(72, 0);
    run_random_phase(PHASE_ITEMS);
    configure(16'hFFFF, 11'd0);
    set_pressure(0, 72);
    run_random_phase(PHASE_ITEMS);
    configure(16'($urandom_range(1, 50)), 11'd1);
    set_pressure(17, 17);
    run_random_phase(PHASE_ITEMS);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_window_edges();
    test_limit_and_clear();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    $display("Covered %0d record, check, clear and unused commands and %0d register writes,",
             items_accepted, cfg_writes);
    $display("with window and limit corner cases and four pressure settings; %0d results compared.",
             results_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
